// File: design/heightfield_interp_deform_defines.svh
// Assertion macros used by the height-field interpolator checker.
`ifndef HEIGHTFIELD_INTERP_DEFORM_DEFINES_SVH
`define HEIGHTFIELD_INTERP_DEFORM_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HFID_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HFID_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: design/hfid_pkg.sv
`timescale 1ns / 1ps
// Package with types, constants and arithmetic helpers of the height-field interpolator.
package hfid_pkg;

    localparam int NUM_POINTS_DEFAULT = 4096;

    localparam int POS_W      = 32;
    localparam int H_W        = 24;
    localparam int TW_W       = 16;
    localparam int IDX_W      = 12;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_W      = 40;
    localparam int DIV_CNT_W  = 6;
    localparam int PROD_W     = 42;
    localparam int SHARE_W    = 25;
    localparam int SUM_W      = 26;

    localparam logic [TW_W-1:0] TILE_WIDTH_RESET = 16'd3277;

    // Raise shares in Q0.16: 0.6 and 0.2.
    localparam logic signed [TW_W:0] SHARE_MAIN = 17'sd39322;
    localparam logic signed [TW_W:0] SHARE_SIDE = 17'sd13107;

    localparam logic [CFG_ADDR_W-1:0] CFG_START_OFFSET = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TILE_WIDTH   = 1'b1;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_RAISE = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_CLAMPED = 2'd1;
    localparam logic [1:0] STATUS_SKIPPED = 2'd2;

    typedef struct packed {
        logic [1:0]              cmd;
        logic signed [POS_W-1:0] position;
        logic [IDX_W-1:0]        entry_index;
        logic signed [H_W-1:0]   value;
    } hfid_in_t;

    typedef struct packed {
        logic signed [H_W-1:0] height;
        logic [1:0]            status;
    } hfid_out_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
        logic [DIV_W-1:0]     dividend;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [TW_W-1:0]  remainder;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_DIV_A,
        ST_CLAMP_RD,
        ST_CLAMP_CAP,
        ST_RD0,
        ST_RD1,
        ST_MUL,
        ST_DIV_B_GO,
        ST_DIV_B,
        ST_MUL_M,
        ST_MUL_S,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_DONE
    } state_t;

    // Round a Q0.16-scaled product to nearest, halves toward plus infinity.
    function automatic logic signed [SHARE_W-1:0] share_round(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(32768);
        return t[PROD_W-2:TW_W];
    endfunction

    // Saturate a widened height back to 24 bits.
    function automatic logic [H_W-1:0] sat_h(input logic signed [SUM_W-1:0] v);
        logic [H_W-1:0] r;
        if (v[SUM_W-1:H_W-1] == '0 || v[SUM_W-1:H_W-1] == '1) begin
            r = v[H_W-1:0];
        end else if (v[SUM_W-1]) begin
            r = {1'b1, {(H_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(H_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: design/hfid_divider.sv
`timescale 1ns / 1ps
// Restoring divider that retires one quotient bit per cycle.
module hfid_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [hfid_pkg::TW_W-1:0]     divisor,
    input  hfid_pkg::div_req_t            req,
    output hfid_pkg::div_rsp_t            rsp
);
    import hfid_pkg::*;

    logic [DIV_W-1:0]     num_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [TW_W-1:0]      rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [TW_W:0]        trial;
    logic [TW_W:0]        diff;
    logic                 fits;

    // The dividend is consumed from its top bit; the caller left-aligns it.
    assign trial = {rem_reg, num_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.count;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.dividend;
            quo_reg <= '0;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[DIV_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? diff[TW_W-1:0] : trial[TW_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: design/heightfield_interp_deform.sv
`timescale 1ns / 1ps
// Top level of the height-field terrain table with write, interpolated query and local raise.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    s_data  (hfid_in_t: cmd, position, index, value)
//  m_        out        m_valid / m_ready    m_data  (hfid_out_t: height, status)
//  cfg_      in         cfg_wr_en            cfg_addr, cfg_wr_data
//
// A write passes from transfer to result through ST_DIFF and ST_DONE; a query and a raise also
// wait on the divider, which computes 32 quotient bits for the grid index and 40 for the blend.
// Reset is synchronous and active low; it clears control state and the configuration registers,
// but not the datapath registers or the height table, whose entries are undefined until written.
// A finished result waits in the output register while the next item is taken; a second
// result stalls in the final state until the first has been taken.
module heightfield_interp_deform #(
    parameter int NUM_POINTS = hfid_pkg::NUM_POINTS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [hfid_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [hfid_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  hfid_pkg::hfid_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output hfid_pkg::hfid_out_t                 m_data
);
    import hfid_pkg::*;

    localparam int AW = $clog2(NUM_POINTS);
    localparam int IDX_EXT_W = 17;
    localparam logic [1:0] RMW_LAST = 2'd2;

    // Configuration registers.
    logic signed [POS_W-1:0] start_offset_reg;
    logic [TW_W-1:0]         tile_width_reg;
    logic [TW_W-1:0]         tw_eff;

    // Sequencer and item state.
    state_t                  state_reg, state_next;
    hfid_in_t                in_reg;
    logic signed [POS_W:0]   d_reg;
    logic [POS_W:0]          d_abs;
    logic [AW-1:0]           i_addr_reg;
    logic signed [TW_W:0]    f_reg;
    logic [H_W-1:0]          h0_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0]       prod_abs;
    logic signed [SHARE_W-1:0] share_m_reg;
    logic [1:0]              rmw_cnt_reg;
    logic [H_W-1:0]          res_height_reg;
    logic [1:0]              res_status_reg;

    // Output register.
    logic                    m_valid_reg;
    hfid_out_t               m_data_reg;
    logic                    out_load;

    // Height table.
    logic [H_W-1:0]          heights_mem [NUM_POINTS];
    logic [H_W-1:0]          rd_data_reg;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [AW-1:0]           mem_raddr;
    logic [H_W-1:0]          mem_wdata;

    // Shared divider and multiplier.
    div_req_t                div_req;
    div_rsp_t                div_rsp;
    logic signed [H_W:0]     mul_a;
    logic signed [TW_W:0]    mul_b;
    logic signed [PROD_W-1:0] mul_p;

    // Decisions taken on the grid index.
    logic                    neg;
    logic                    q_zero;
    logic                    q_high;
    logic                    clamp_lo;
    logic                    clamp_hi;
    logic                    raise_skip;
    logic [IDX_EXT_W-1:0]    idx_ext;
    logic                    idx_ok;
    logic [AW-1:0]           rmw_addr;
    logic signed [SHARE_W-1:0] share_cur;
    logic signed [SUM_W-1:0] rmw_sum;
    logic [SHARE_W-1:0]      blend_q;
    logic signed [SUM_W-1:0] blend_adj;
    logic signed [SUM_W-1:0] blend_sum;

    // A zero tile width behaves as the smallest spacing.
    assign tw_eff = (tile_width_reg == '0) ? TW_W'(1) : tile_width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_offset_reg <= '0;
            tile_width_reg   <= TILE_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_START_OFFSET: start_offset_reg <= cfg_wr_data[POS_W-1:0];
                CFG_TILE_WIDTH:   tile_width_reg   <= cfg_wr_data[TW_W-1:0];
                default: ;
            endcase
        end
    end

    hfid_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .divisor (tw_eff),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // The signed quotient is carried as sign and magnitude; truncation toward zero
    // falls out of dividing the magnitude and reapplying the sign.
    assign d_abs    = d_reg[POS_W] ? -d_reg : d_reg;
    assign prod_abs = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;

    assign neg        = d_reg[POS_W];
    assign q_zero     = (div_rsp.quotient == '0);
    assign q_high     = (div_rsp.quotient >= DIV_W'(NUM_POINTS - 1));
    assign clamp_lo   = neg && !q_zero;
    assign clamp_hi   = !neg && q_high;
    assign raise_skip = neg || q_zero || q_high;

    assign idx_ext = IDX_EXT_W'(in_reg.entry_index);
    assign idx_ok  = (idx_ext < IDX_EXT_W'(NUM_POINTS));

    // Raise visits the left neighbour, the center and the right neighbour in turn.
    assign rmw_addr  = i_addr_reg + AW'(rmw_cnt_reg) - AW'(1);
    assign share_cur = (rmw_cnt_reg == 2'd1) ? share_m_reg : share_round(prod_reg);
    assign rmw_sum   = SUM_W'(signed'(rd_data_reg)) + SUM_W'(share_cur);

    // Blend: h0 plus the signed quotient of (h1 - h0) * f by the tile width.
    assign blend_q   = div_rsp.quotient[SHARE_W-1:0];
    assign blend_adj = prod_reg[PROD_W-1] ? -SUM_W'(blend_q) : SUM_W'(blend_q);
    assign blend_sum = SUM_W'(signed'(h0_reg)) + blend_adj;

    assign mul_p = mul_a * mul_b;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF: begin
                if (in_reg.cmd == CMD_QUERY || in_reg.cmd == CMD_RAISE) begin
                    state_next = ST_DIV_A;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV_A: begin
                if (div_rsp.done) begin
                    if (in_reg.cmd == CMD_QUERY) begin
                        state_next = (clamp_lo || clamp_hi) ? ST_CLAMP_RD : ST_RD0;
                    end else begin
                        state_next = raise_skip ? ST_DONE : ST_MUL_M;
                    end
                end
            end
            ST_CLAMP_RD:  state_next = ST_CLAMP_CAP;
            ST_CLAMP_CAP: state_next = ST_DONE;
            ST_RD0:       state_next = ST_RD1;
            ST_RD1:       state_next = ST_MUL;
            ST_MUL:       state_next = ST_DIV_B_GO;
            ST_DIV_B_GO:  state_next = ST_DIV_B;
            ST_DIV_B: begin
                if (div_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL_M:     state_next = ST_MUL_S;
            ST_MUL_S:     state_next = ST_RMW_RD;
            ST_RMW_RD:    state_next = ST_RMW_WR;
            ST_RMW_WR: begin
                state_next = (rmw_cnt_reg == RMW_LAST) ? ST_DONE : ST_RMW_RD;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: memory port, divider request, multiplier operands and output load.
    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = rmw_addr;
        mem_wdata    = sat_h(rmw_sum);
        mem_raddr    = i_addr_reg;
        div_req      = '0;
        mul_a        = '0;
        mul_b        = '0;
        out_load     = 1'b0;
        case (state_reg)
            ST_DIFF: begin
                if (in_reg.cmd == CMD_WRITE) begin
                    mem_we    = idx_ok;
                    mem_waddr = idx_ext[AW-1:0];
                    mem_wdata = in_reg.value;
                end else if (in_reg.cmd == CMD_QUERY || in_reg.cmd == CMD_RAISE) begin
                    div_req.start    = 1'b1;
                    div_req.count    = DIV_CNT_W'(POS_W);
                    div_req.dividend = {d_abs[POS_W-1:0], {(DIV_W-POS_W){1'b0}}};
                end
            end
            ST_RD1: mem_raddr = i_addr_reg + AW'(1);
            ST_MUL: begin
                mul_a = (H_W+1)'(signed'(rd_data_reg)) - (H_W+1)'(signed'(h0_reg));
                mul_b = f_reg;
            end
            ST_DIV_B_GO: begin
                div_req.start    = 1'b1;
                div_req.count    = DIV_CNT_W'(DIV_W);
                div_req.dividend = prod_abs[DIV_W-1:0];
            end
            ST_MUL_M: begin
                mul_a = (H_W+1)'(in_reg.value);
                mul_b = SHARE_MAIN;
            end
            ST_MUL_S: begin
                mul_a = (H_W+1)'(in_reg.value);
                mul_b = SHARE_SIDE;
            end
            ST_RMW_RD: mem_raddr = rmw_addr;
            ST_RMW_WR: mem_we = 1'b1;
            ST_DONE:   out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rmw_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_MUL_S) begin
                rmw_cnt_reg <= '0;
            end else if (state_reg == ST_RMW_WR) begin
                rmw_cnt_reg <= rmw_cnt_reg + 2'd1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_reg         <= s_data;
                    d_reg          <= (POS_W+1)'(s_data.position)
                                    - (POS_W+1)'(start_offset_reg);
                    res_height_reg <= '0;
                    res_status_reg <= STATUS_OK;
                end
            end
            ST_DIV_A: begin
                if (div_rsp.done) begin
                    if (clamp_lo) begin
                        i_addr_reg <= '0;
                    end else if (clamp_hi) begin
                        i_addr_reg <= AW'(NUM_POINTS - 1);
                    end else begin
                        i_addr_reg <= div_rsp.quotient[AW-1:0];
                    end
                    f_reg <= neg ? -{1'b0, div_rsp.remainder} : {1'b0, div_rsp.remainder};
                    if (in_reg.cmd == CMD_QUERY && (clamp_lo || clamp_hi)) begin
                        res_status_reg <= STATUS_CLAMPED;
                    end
                    if (in_reg.cmd == CMD_RAISE && raise_skip) begin
                        res_status_reg <= STATUS_SKIPPED;
                    end
                end
            end
            ST_CLAMP_CAP: res_height_reg <= rd_data_reg;
            ST_RD1:       h0_reg <= rd_data_reg;
            ST_MUL:       prod_reg <= mul_p;
            ST_MUL_M:     prod_reg <= mul_p;
            ST_MUL_S: begin
                share_m_reg <= share_round(prod_reg);
                prod_reg    <= mul_p;
            end
            ST_DIV_B: begin
                if (div_rsp.done) begin
                    res_height_reg <= sat_h(blend_sum);
                end
            end
            default: ;
        endcase
    end

    // Table storage with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            heights_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= heights_mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.height <= res_height_reg;
            m_data_reg.status <= res_status_reg;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: design/hfid_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the height-field interpolator and its bind.
`include "heightfield_interp_deform_defines.svh"

module hfid_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input hfid_pkg::hfid_out_t m_data
);
    import hfid_pkg::*;

    // One item at a time: a transfer on the input closes it for the next cycle.
    `HFID_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A stalled result holds its value.
    `HFID_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data))

    // A skipped raise never reports a height.
    `HFID_ASSERT_SAME(a_skip_zero, aclk, aresetn,
        m_valid && (m_data.status == STATUS_SKIPPED), m_data.height == '0)

endmodule

bind heightfield_interp_deform hfid_checker u_hfid_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
